// ----- rtl/core/jsg_pkg.sv -----
// Package for the joint stall guard: field widths, direction and register codes,
// and the structs passed between the top level and the per-tick step logic.
// No dependencies.
package jsg_pkg;

  localparam int AxisW    = 16;
  localparam int PosW     = 32;
  localparam int CurW     = 16;
  localparam int TickW    = 20;
  localparam int LimW     = 31;
  localparam int CurLimW  = 16;
  localparam int TimeW    = 24;
  localparam int DirW     = 2;
  localparam int CfgIdxW  = 2;
  localparam int InDataW  = 152;
  localparam int OutDataW = 48;

  localparam logic signed [AxisW-1:0] AxisOne    = 16'sd16384;
  localparam logic signed [AxisW-1:0] AxisNegOne = -16'sd16384;

  localparam logic [DirW-1:0] DirNone = 2'd0;
  localparam logic [DirW-1:0] DirPos  = 2'd1;
  localparam logic [DirW-1:0] DirNeg  = 2'd2;

  localparam logic [CfgIdxW-1:0] RegCurrentLimit  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegVelocityLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPosErrLimit   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStallTimeout  = 2'd3;

  typedef struct packed {
    logic                    enabled;
    logic signed [AxisW-1:0] jog_axis;
    logic signed [PosW-1:0]  target_position;
    logic signed [PosW-1:0]  measured_position;
    logic signed [PosW-1:0]  measured_velocity;
    logic signed [CurW-1:0]  commanded_current;
    logic [TickW-1:0]        tick_us;
  } tick_in_t;

  typedef struct packed {
    logic [CurLimW-1:0] current_limit;
    logic [LimW-1:0]    velocity_limit;
    logic [LimW-1:0]    position_error_limit;
    logic [TimeW-1:0]   stall_timeout_us;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] stall_elapsed;
    logic [DirW-1:0]  lock_dir;
  } guard_state_t;

  typedef struct packed {
    logic signed [AxisW-1:0] allowed_axis;
    logic                    hold_pulse;
    logic [DirW-1:0]         blocked_dir;
    logic [TimeW-1:0]        stall_time_us;
  } tick_out_t;

endpackage

// ----- rtl/core/jsg_step.sv -----
// Per-tick stall qualification and direction blocking logic.
// Combinational; depends on jsg_pkg.
module jsg_step (
  input  jsg_pkg::tick_in_t     tick,
  input  jsg_pkg::cfg_t         cfg,
  input  jsg_pkg::guard_state_t state,
  output jsg_pkg::guard_state_t state_next,
  output jsg_pkg::tick_out_t    result
);
  import jsg_pkg::*;

  logic signed [AxisW-1:0] axis;
  logic [DirW-1:0]         req;
  logic signed [PosW:0]    err;
  logic signed [PosW:0]    lim_pos;
  logic signed [PosW:0]    lim_neg;
  logic [CurW:0]           cur_mag;
  logic [PosW:0]           vel_mag;
  logic                    invalid;
  logic                    loaded;
  logic                    high;
  logic                    still;
  logic                    opposite;
  logic [TimeW:0]          sum;
  logic [TimeW+2:0]        lhs;
  logic [TimeW+2:0]        rhs;

  always_comb begin
    invalid = !tick.enabled || (tick.tick_us == '0) || (cfg.current_limit == '0) ||
              (cfg.velocity_limit == '0) || (cfg.position_error_limit == '0) ||
              (cfg.stall_timeout_us == '0);

    if (tick.jog_axis > AxisOne) begin
      axis = AxisOne;
    end else if (tick.jog_axis < AxisNegOne) begin
      axis = AxisNegOne;
    end else begin
      axis = tick.jog_axis;
    end
    req = (axis > 0) ? DirPos : ((axis < 0) ? DirNeg : DirNone);

    err     = {tick.target_position[PosW-1], tick.target_position} -
              {tick.measured_position[PosW-1], tick.measured_position};
    lim_pos = $signed({2'b00, cfg.position_error_limit});
    lim_neg = -lim_pos;
    loaded  = ((req == DirPos) && (err >= lim_pos)) ||
              ((req == DirNeg) && (err <= lim_neg));

    cur_mag = tick.commanded_current[CurW-1] ?
              (~{1'b1, tick.commanded_current} + 1'b1) : {1'b0, tick.commanded_current};
    vel_mag = tick.measured_velocity[PosW-1] ?
              (~{1'b1, tick.measured_velocity} + 1'b1) : {1'b0, tick.measured_velocity};
    high    = cur_mag >= {1'b0, cfg.current_limit};
    still   = vel_mag >= {2'b00, cfg.velocity_limit} ? (vel_mag == {2'b00, cfg.velocity_limit})
                                                     : 1'b1;

    opposite = ((req == DirPos) && (state.lock_dir == DirNeg)) ||
               ((req == DirNeg) && (state.lock_dir == DirPos));

    sum = {1'b0, state.stall_elapsed} + {{(TimeW+1-TickW){1'b0}}, tick.tick_us};
    lhs = {1'b0, sum, 1'b0} + {{(TimeW+3-TickW){1'b0}}, tick.tick_us};
    rhs = {2'b00, cfg.stall_timeout_us, 1'b0};

    state_next = state;
    result     = '0;

    if (invalid) begin
      state_next = '0;
    end else if (state.lock_dir != DirNone) begin
      if (opposite) begin
        state_next          = '0;
        result.allowed_axis = axis;
      end else begin
        result.blocked_dir   = state.lock_dir;
        result.stall_time_us = state.stall_elapsed;
      end
    end else if ((req == DirNone) || !loaded || !high || !still) begin
      state_next.stall_elapsed = '0;
      result.allowed_axis      = axis;
    end else if (lhs >= rhs) begin
      state_next.stall_elapsed = cfg.stall_timeout_us;
      state_next.lock_dir      = req;
      result.hold_pulse        = 1'b1;
      result.blocked_dir       = req;
      result.stall_time_us     = cfg.stall_timeout_us;
    end else begin
      state_next.stall_elapsed = sum[TimeW-1:0];
      result.allowed_axis      = axis;
      result.stall_time_us     = sum[TimeW-1:0];
    end
  end

endmodule

// ----- rtl/core/joint_stall_guard_unit.sv -----
// Joint stall guard, top level: stream ports, configuration registers,
// input and result registers around the step logic. Depends on jsg_pkg, jsg_step.
//
// The block accepts one request per clock while the receiver takes each result, and
// returns one result per request, in order. A request accepted at a clock edge waits
// in the input register until the result register is free; stepping it then loads
// its result into the result register and offers it. While the receiver holds a
// result, the next request waits in the input register and no further request is
// accepted until the result leaves. The stall timer and blocked direction update in
// the cycle a request moves from the input register to the result register, so each
// request sees the state left by the one before it.
module joint_stall_guard_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [jsg_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [jsg_pkg::LimW-1:0]        cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // enabled, jog_axis, target_position, measured_position,
  // measured_velocity, commanded_current, tick_us, zero fill
  input  logic [jsg_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // allowed_axis, hold_pulse, blocked_dir, stall_time_us, zero fill
  output logic [jsg_pkg::OutDataW-1:0]    m_axis_tdata
);
  import jsg_pkg::*;

  cfg_t         cfg;
  guard_state_t state;
  guard_state_t state_next;
  tick_in_t     tick;
  tick_in_t     tick_unpacked;
  tick_out_t    result;
  tick_out_t    result_next;
  logic         in_valid;
  logic         out_free;
  logic         step;

  assign tick_unpacked.enabled           = s_axis_tdata[0];
  assign tick_unpacked.jog_axis          = s_axis_tdata[16:1];
  assign tick_unpacked.target_position   = s_axis_tdata[48:17];
  assign tick_unpacked.measured_position = s_axis_tdata[80:49];
  assign tick_unpacked.measured_velocity = s_axis_tdata[112:81];
  assign tick_unpacked.commanded_current = s_axis_tdata[128:113];
  assign tick_unpacked.tick_us           = s_axis_tdata[148:129];

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || step;

  jsg_step u_step (
    .tick       (tick),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegCurrentLimit:  cfg.current_limit        <= cfg_data[CurLimW-1:0];
        RegVelocityLimit: cfg.velocity_limit       <= cfg_data;
        RegPosErrLimit:   cfg.position_error_limit <= cfg_data;
        RegStallTimeout:  cfg.stall_timeout_us     <= cfg_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      state         <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (step) begin
        in_valid <= 1'b0;
      end
      if (step) begin
        m_axis_tvalid <= 1'b1;
        state         <= state_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tick <= tick_unpacked;
    end
    if (step) begin
      result <= result_next;
    end
  end

  assign m_axis_tdata = {{(OutDataW-AxisW-1-DirW-TimeW){1'b0}}, result.stall_time_us,
                         result.blocked_dir, result.hold_pulse, result.allowed_axis};

`ifndef SYNTH
  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    state.lock_dir != 2'd3)
    else $error("blocked direction holds an unused code");

  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && result.hold_pulse |->
      (result.allowed_axis == '0) && (result.blocked_dir != DirNone) &&
      (result.blocked_dir == state.lock_dir))
    else $error("hold result does not match a new block");

  a_block_start: assert property (@(posedge clk) disable iff (rst)
    step && (state.lock_dir == DirNone) && (state_next.lock_dir != DirNone)
      |=> m_axis_tvalid && result.hold_pulse)
    else $error("block began without a hold result");
`endif

endmodule

// ----- test/tb_joint_stall_guard_unit.sv -----
// Self-checking testbench for joint_stall_guard_unit: directed and random jog ticks
// on the request stream, checked against an in-bench model of the stall guard.
// Depends on jsg_pkg and the joint_stall_guard_unit RTL.
module tb_joint_stall_guard_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import jsg_pkg::*;

  localparam int WatchLimit = 5000;
  localparam logic [LimW-1:0] LimMax = 31'h7FFFFFFF;
  localparam logic [TimeW-1:0] TimeMax = 24'hFFFFFF;
  localparam int unsigned TickMax = 20'hFFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [LimW-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  cfg_t guard_cfg = '0;
  logic [TimeW-1:0] stall_timer = '0;
  logic [DirW-1:0] stall_dir = DirNone;
  tick_out_t pending_out[$];

  int src_idle_pct = 8;
  int sink_stall_pct = 45;
  int items_sent = 0;
  int results_seen = 0;
  int blocks_seen = 0;
  int settings_used = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  joint_stall_guard_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  function automatic tick_out_t guard_response(input tick_in_t t);
    tick_out_t r;
    logic signed [AxisW-1:0] ax;
    logic [DirW-1:0] req;
    longint err, cm, vm;
    longint unsigned nxt;
    logic loaded;
    r = '0;
    if (!t.enabled || t.tick_us == 0 || guard_cfg.current_limit == 0 ||
        guard_cfg.velocity_limit == 0 || guard_cfg.position_error_limit == 0 ||
        guard_cfg.stall_timeout_us == 0) begin
      stall_timer = '0;
      stall_dir = DirNone;
      return r;
    end
    ax = t.jog_axis;
    if (ax > AxisOne) ax = AxisOne;
    else if (ax < AxisNegOne) ax = AxisNegOne;
    req = (ax > 0) ? DirPos : ((ax < 0) ? DirNeg : DirNone);
    if (stall_dir != DirNone) begin
      if ((req == DirPos && stall_dir == DirNeg) || (req == DirNeg && stall_dir == DirPos)) begin
        stall_dir = DirNone;
        stall_timer = '0;
        r.allowed_axis = ax;
      end
      r.blocked_dir = stall_dir;
      r.stall_time_us = stall_timer;
      return r;
    end
    r.allowed_axis = ax;
    if (req == DirNone) begin
      stall_timer = '0;
      return r;
    end
    err = longint'(t.target_position) - longint'(t.measured_position);
    loaded = (req == DirPos) ? (err >= longint'(guard_cfg.position_error_limit))
                             : (err <= -longint'(guard_cfg.position_error_limit));
    cm = t.commanded_current;
    vm = t.measured_velocity;
    if (cm < 0) cm = -cm;
    if (vm < 0) vm = -vm;
    if (!loaded || cm < longint'(guard_cfg.current_limit) ||
        vm > longint'(guard_cfg.velocity_limit)) begin
      stall_timer = '0;
      return r;
    end
    nxt = longint'(stall_timer) + longint'(t.tick_us);
    if (2 * nxt + t.tick_us >= 2 * longint'(guard_cfg.stall_timeout_us)) begin
      stall_timer = guard_cfg.stall_timeout_us;
      stall_dir = req;
      r.allowed_axis = '0;
      r.hold_pulse = 1'b1;
      r.blocked_dir = req;
    end else begin
      stall_timer = nxt[TimeW-1:0];
    end
    r.stall_time_us = stall_timer;
    return r;
  endfunction

  function automatic logic signed [AxisW-1:0] axis_toward(input logic [DirW-1:0] dir);
    int m;
    case ($urandom_range(3))
      0: m = 16384;
      1: m = $urandom_range(16385, 32768);
      default: m = $urandom_range(1, 16383);
    endcase
    if (dir == DirPos) return AxisW'((m > 32767) ? 32767 : m);
    return AxisW'(-m);
  endfunction

  function automatic tick_in_t noise_tick();
    tick_in_t t;
    t.enabled = ($urandom_range(9) != 0);
    t.jog_axis = AxisW'($urandom);
    t.target_position = $urandom;
    t.measured_position = $urandom;
    t.measured_velocity = $urandom;
    t.commanded_current = CurW'($urandom);
    t.tick_us = ($urandom_range(19) == 0) ? '0 : TickW'($urandom);
    return t;
  endfunction

  function automatic tick_in_t follow_tick(input logic [DirW-1:0] dir);
    tick_in_t t;
    t = noise_tick();
    t.enabled = 1'b1;
    t.tick_us = TickW'($urandom_range(1, TickMax));
    t.jog_axis = (dir == DirNone) ? '0 : axis_toward(dir);
    return t;
  endfunction

  // A tick meeting all stall conditions toward dir, unless flaw breaks one or current_limit exceeds 32768.
  function automatic tick_in_t stall_tick(input logic [DirW-1:0] dir, input int flaw);
    tick_in_t t;
    longint e, lo, hi, tgt, vl, vm, cl, cm;
    int unsigned tmax;
    t.enabled = 1'b1;
    t.jog_axis = axis_toward(dir);
    e = longint'(guard_cfg.position_error_limit);
    if (flaw == 1) e = e - 1 - $urandom_range(0, 3);
    else if ($urandom_range(3) != 0) e = e + $urandom_range(0, 4095);
    if (dir == DirNeg) e = -e;
    if (e >= 0) begin
      lo = -64'sd2147483648 + e;
      hi = 64'sd2147483647;
    end else begin
      lo = -64'sd2147483648;
      hi = 64'sd2147483647 + e;
    end
    tgt = lo + (longint'($urandom) % (hi - lo + 1));
    t.target_position = 32'(tgt);
    t.measured_position = 32'(tgt - e);
    vl = longint'(guard_cfg.velocity_limit);
    if (flaw == 2) vm = vl + 1;
    else if ($urandom_range(3) == 0) vm = vl;
    else vm = longint'($urandom_range(0, vl));
    t.measured_velocity = 32'((vm == 64'sd2147483648 || $urandom_range(1) == 0) ? -vm : vm);
    cl = longint'(guard_cfg.current_limit);
    if (flaw == 3) cm = (cl == 0) ? 0 : $urandom_range(0, (cl > 32768) ? 32768 : cl - 1);
    else if (cl > 32768) cm = 32768;
    else if ($urandom_range(3) == 0) cm = cl;
    else cm = $urandom_range(cl, 32768);
    t.commanded_current = CurW'((cm == 32768 || $urandom_range(1) == 0) ? -cm : cm);
    tmax = guard_cfg.stall_timeout_us / 3;
    if (tmax == 0) tmax = 1;
    if (tmax > TickMax) tmax = TickMax;
    t.tick_us = TickW'(($urandom_range(1) == 0) ? $urandom_range(1, tmax)
                                                : $urandom_range(1, TickMax));
    if (flaw == 4) t.enabled = 1'b0;
    if (flaw == 5) t.tick_us = '0;
    if (flaw == 6) t.jog_axis = '0;
    return t;
  endfunction

  task automatic send_tick(input tick_in_t t);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, t.tick_us, t.commanded_current, t.measured_velocity,
                     t.measured_position, t.target_position, t.jog_axis, t.enabled};
    do @(posedge clk); while (!s_axis_tready);
    pending_out.push_back(guard_response(t));
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LimW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
  endtask

  task automatic write_limits(input logic [LimW-1:0] cl, vl, pl, to);
    write_reg(RegCurrentLimit, cl);
    write_reg(RegVelocityLimit, vl);
    write_reg(RegPosErrLimit, pl);
    write_reg(RegStallTimeout, to);
    @(negedge clk);
    cfg_we <= 1'b0;
    guard_cfg.current_limit = cl[CurLimW-1:0];
    guard_cfg.velocity_limit = vl;
    guard_cfg.position_error_limit = pl;
    guard_cfg.stall_timeout_us = to[TimeW-1:0];
    settings_used++;
  endtask

  task automatic test_unconfigured();
    repeat (4) send_tick(stall_tick(DirPos, 0));
    wait_idle();
  endtask

  task automatic test_axis_clamp();
    logic signed [AxisW-1:0] axes[5];
    tick_in_t t;
    axes = '{16'sd32767, -16'sd32768, 16'sd16385, -16'sd16385, 16'sd0};
    write_limits(31'd1000, 31'h8000, 31'h10000, 31'd5000);
    foreach (axes[i]) begin
      t = follow_tick(DirNone);
      t.commanded_current = '0;
      t.jog_axis = axes[i];
      send_tick(t);
    end
    t.jog_axis = 16'sd32767;
    t.enabled = 1'b0;
    send_tick(t);
    t.enabled = 1'b1;
    t.tick_us = '0;
    send_tick(t);
  endtask

  task automatic test_stall_block();
    tick_in_t t;
    for (int k = 0; k < 10 && stall_dir == DirNone; k++) send_tick(stall_tick(DirPos, 0));
    send_tick(follow_tick(DirPos));
    send_tick(follow_tick(DirNone));
    send_tick(follow_tick(DirNeg));
    for (int k = 0; k < 10 && stall_dir == DirNone; k++) send_tick(stall_tick(DirNeg, 0));
    t = follow_tick(DirPos);
    t.enabled = 1'b0;
    send_tick(t);
    wait_idle();
  endtask

  // With a 10 us timeout, 7 us blocks from zero; 6, 2 and 1 stay short, the next 1 blocks.
  task automatic test_timeout_edge();
    int unsigned dts[6];
    tick_in_t t;
    dts = '{7, 0, 6, 2, 1, 1};
    write_limits(31'd1000, 31'h8000, 31'h10000, 31'd10);
    foreach (dts[i]) begin
      if (dts[i] == 0) begin
        send_tick(follow_tick(DirNeg));
      end else begin
        t = stall_tick(DirPos, 0);
        t.tick_us = TickW'(dts[i]);
        send_tick(t);
      end
    end
    wait_idle();
  endtask

  task automatic test_zero_register();
    for (int i = 0; i < 4; i++) begin
      write_limits((i == 0) ? 31'd0 : 31'd1000, (i == 1) ? 31'd0 : 31'h8000,
                   (i == 2) ? 31'd0 : 31'h10000, (i == 3) ? 31'd0 : 31'd5000);
      send_tick(stall_tick(DirPos, 0));
      wait_idle();
    end
  endtask

  task automatic run_episodes(input int count);
    int start;
    logic [DirW-1:0] dir;
    tick_in_t t;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(9) < 7) begin
        dir = ($urandom_range(1) == 0) ? DirPos : DirNeg;
        for (int k = 0; k < 40 && stall_dir == DirNone; k++)
          send_tick(stall_tick(dir, ($urandom_range(11) == 0) ? $urandom_range(1, 6) : 0));
        repeat ($urandom_range(0, 3))
          send_tick(follow_tick(($urandom_range(1) == 0) ? dir : DirNone));
        t = follow_tick((dir == DirPos) ? DirNeg : DirPos);
        if ($urandom_range(9) == 0) t.enabled = 1'b0;
        send_tick(t);
      end else begin
        repeat ($urandom_range(1, 4)) send_tick(noise_tick());
      end
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int seg = 0; seg < 8; seg++) begin
      if (seg == 3) begin
        src_idle_pct = 45;
        sink_stall_pct = 8;
      end
      if (seg == 6) begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      case (seg)
        0: write_limits(31'd1000, 31'h8000, 31'h10000, 31'd5000);
        1: write_limits(31'd1, 31'd1, 31'd1, 31'd1);
        2: write_limits(31'd32768, LimMax, LimMax, 31'(TimeMax));
        4: write_limits(LimMax, LimMax, LimMax, LimMax);
        7: write_limits(31'd500, 31'h100, 31'h4000, 31'd1000000);
        default: write_limits(31'($urandom_range(1, 32768)), 31'($urandom_range(1, LimMax)),
                              31'($urandom_range(1, LimMax)), 31'($urandom_range(1, TimeMax)));
      endcase
      run_episodes((seg == 4) ? 100 : 200);
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    tick_out_t got, want;
    logic bad;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.allowed_axis = m_axis_tdata[15:0];
      got.hold_pulse = m_axis_tdata[16];
      got.blocked_dir = m_axis_tdata[18:17];
      got.stall_time_us = m_axis_tdata[42:19];
      results_seen++;
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_out.pop_front();
        bad = 1'b0;
        if (got.hold_pulse === 1'b1) blocks_seen++;
        if (got.allowed_axis !== want.allowed_axis) begin
          $display("%0t: allowed_axis expected %0d, got %0d", $time, want.allowed_axis,
                   got.allowed_axis);
          bad = 1'b1;
        end
        if (got.hold_pulse !== want.hold_pulse) begin
          $display("%0t: hold_pulse expected %0d, got %0d", $time, want.hold_pulse,
                   got.hold_pulse);
          bad = 1'b1;
        end
        if (got.blocked_dir !== want.blocked_dir) begin
          $display("%0t: blocked_dir expected %0d, got %0d", $time, want.blocked_dir,
                   got.blocked_dir);
          bad = 1'b1;
        end
        if (got.stall_time_us !== want.stall_time_us) begin
          $display("%0t: stall_time_us expected %0d, got %0d", $time, want.stall_time_us,
                   got.stall_time_us);
          bad = 1'b1;
        end
        if (bad) mismatches++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_out.size() == 0 && !s_axis_tvalid)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("%0t: no request or result moved for %0d cycles", $time, WatchLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_unconfigured();
    test_axis_clamp();
    test_stall_block();
    test_timeout_edge();
    test_zero_register();
    test_random_traffic();
    wait_idle();
    $display("Sent %0d jog ticks, checked %0d results, saw %0d stall blocks.",
             items_sent, results_seen, blocks_seen);
    $display("Used %0d limit settings, with and without idle cycles on either side.",
             settings_used);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/jsg_pkg.sv
rtl/core/jsg_step.sv
rtl/core/joint_stall_guard_unit.sv
test/tb_joint_stall_guard_unit.sv
